[rtl/core/bli_pkg.sv]
package bli_pkg;

  localparam int unsigned DefCapacity = 16;

  localparam int unsigned KindW = 2;
  localparam int unsigned PosW = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountOutW = 5;

  localparam logic [KindW-1:0] KindInsert = 2'd0;
  localparam logic [KindW-1:0] KindRemove = 2'd1;
  localparam logic [KindW-1:0] KindRead = 2'd2;
  localparam logic [KindW-1:0] KindReverse = 2'd3;

  typedef enum logic [1:0] {
    CellHold,
    CellLeft,
    CellRight,
    CellLoad
  } cell_op_e;

  typedef logic signed [DataW-1:0] data_t;

endpackage

[rtl/core/bounded_indexed_list.sv]
// A request is accepted only in the idle state, then passes through a selection state
// and a finish state before the next one is taken. The read selection across the row of
// cells is two-level and registered; a waiting result delays only the finish step.
// Reset empties the list and clears the reversal flag; cell contents stay undefined
// until written. No clearing pass is needed.
module bounded_indexed_list #(
  parameter int unsigned Capacity = bli_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bli_pkg::KindW-1:0]            kind_i,
  input  logic signed [bli_pkg::PosW-1:0]      position_i,
  input  logic signed [bli_pkg::DataW-1:0]     value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bli_pkg::DataW-1:0]     result_value_o,
  output logic                                 error_o,
  output logic [bli_pkg::CountOutW-1:0]        entry_count_o
);
  import bli_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned GBits = (IdxW >= 4) ? 4 : IdxW;
  localparam int unsigned NGW = (IdxW > GBits) ? (IdxW - GBits) : 1;
  localparam int unsigned SelW = NGW + GBits;
  localparam int unsigned PadDepth = 1 << SelW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSel = 2'd1;
  localparam logic [1:0] StFin = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rev_q, rev_d;
  logic            out_valid_q;

  logic [KindW-1:0] kind_q;
  logic [IdxW-1:0]  pos_q;
  data_t            value_q;
  logic             err_q;
  data_t            result_q;
  logic             error_q;
  logic [CountOutW-1:0] cnt_out_q;

  logic in_fire, fin_go;
  assign in_ready_o = (state_q == StIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign fin_go = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // Position clamping and mapping to a physical cell, taking the reversal flag into account.
  logic signed [PosW:0] pos_ext, cnt_ext;
  logic [CntW-1:0] lidx, phys;
  logic            is_ins, err_in;

  always_comb begin
    is_ins = (kind_i == KindInsert);
    pos_ext = {position_i[PosW-1], position_i};
    cnt_ext = signed'({{(PosW + 1 - CntW){1'b0}}, count_q});
    if (pos_ext <= 0) begin
      lidx = '0;
    end else if (pos_ext >= cnt_ext) begin
      lidx = is_ins ? count_q : count_q - CntW'(1);
    end else begin
      lidx = position_i[CntW-1:0];
    end
    if (!rev_q) begin
      phys = lidx;
    end else if (is_ins) begin
      phys = count_q - lidx;
    end else begin
      phys = count_q - lidx - CntW'(1);
    end
    unique case (kind_i)
      KindInsert:  err_in = (count_q == CntW'(Capacity));
      KindRemove:  err_in = (count_q == '0);
      KindRead:    err_in = (count_q == '0);
      KindReverse: err_in = 1'b0;
      default:     err_in = 1'b0;
    endcase
  end

  data_t     cells_w [Capacity];
  data_t     sel_in [PadDepth];
  cell_op_e  cell_op [Capacity];
  data_t     sel_data;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      cell_op[i] = CellHold;
      if (fin_go && !err_q) begin
        if (kind_q == KindInsert) begin
          if (IdxW'(i) > pos_q) begin
            cell_op[i] = CellLeft;
          end else if (IdxW'(i) == pos_q) begin
            cell_op[i] = CellLoad;
          end
        end else if (kind_q == KindRemove) begin
          if (IdxW'(i) >= pos_q) begin
            cell_op[i] = CellRight;
          end
        end
      end
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    data_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cells_w[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cells_w[i+1];
    end
    bli_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (value_q),
      .data_o  (cells_w[i])
    );
  end

  for (genvar i = 0; i < PadDepth; i++) begin : g_pad
    if (i < Capacity) begin : g_real
      assign sel_in[i] = cells_w[i];
    end else begin : g_zero
      assign sel_in[i] = '0;
    end
  end

  bli_sel #(
    .GBits (GBits),
    .NGW   (NGW)
  ) u_sel (
    .clk_i   (clk_i),
    .cells_i (sel_in),
    .idx_i   (SelW'(pos_q)),
    .data_o  (sel_data)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rev_d = rev_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StSel;
        end
      end
      StSel: begin
        state_d = StFin;
      end
      StFin: begin
        if (fin_go) begin
          state_d = StIdle;
          if (!err_q) begin
            if (kind_q == KindInsert) begin
              count_d = count_q + CntW'(1);
            end else if (kind_q == KindRemove) begin
              count_d = count_q - CntW'(1);
            end else if (kind_q == KindReverse) begin
              rev_d = !rev_q;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  logic [CntW+CountOutW-1:0] cnt_wide;
  assign cnt_wide = {{CountOutW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rev_q <= rev_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      pos_q <= phys[IdxW-1:0];
      value_q <= value_i;
      err_q <= err_in;
    end
    if (fin_go) begin
      if (!err_q && (kind_q == KindRemove || kind_q == KindRead)) begin
        result_q <= sel_data;
      end else begin
        result_q <= '0;
      end
      error_q <= err_q;
      cnt_out_q <= cnt_wide[CountOutW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_value_o = result_q;
  assign error_o = error_q;
  assign entry_count_o = cnt_out_q;

endmodule

[rtl/core/bli_cell.sv]
module bli_cell (
  input  logic             clk_i,
  input  bli_pkg::cell_op_e op_i,
  input  bli_pkg::data_t   left_i,
  input  bli_pkg::data_t   right_i,
  input  bli_pkg::data_t   load_i,
  output bli_pkg::data_t   data_o
);
  import bli_pkg::*;

  data_t data_q;
  data_t data_d;

  always_comb begin
    unique case (op_i)
      CellHold:  data_d = data_q;
      CellLeft:  data_d = left_i;
      CellRight: data_d = right_i;
      CellLoad:  data_d = load_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/core/bli_sel.sv]
module bli_sel #(
  parameter int unsigned GBits = 4,
  parameter int unsigned NGW = 1
) (
  input  logic                   clk_i,
  input  bli_pkg::data_t         cells_i [1 << (NGW + GBits)],
  input  logic [NGW+GBits-1:0]   idx_i,
  output bli_pkg::data_t         data_o
);
  import bli_pkg::*;

  localparam int unsigned NG = 1 << NGW;

  data_t grp_q [NG];

  logic [GBits-1:0] off;
  logic [NGW-1:0]   grp;

  assign off = idx_i[GBits-1:0];
  assign grp = idx_i[NGW+GBits-1:GBits];

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NG; g++) begin
      grp_q[g] <= cells_i[{NGW'(g), off}];
    end
  end

  assign data_o = grp_q[grp];

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bli_pkg::*;

  localparam int Capacity = DefCapacity;

  typedef struct {
    logic [KindW-1:0]        kind;
    logic signed [PosW-1:0]  pos;
    data_t                   val;
    int unsigned             gap;
    bit                      drain;
  } list_req_t;

  typedef struct {
    data_t                   val;
    logic                    err;
    logic [CountOutW-1:0]    cnt;
  } list_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [KindW-1:0]            kind_i = KindRead;
  logic signed [PosW-1:0]      position_i = '0;
  logic signed [DataW-1:0]     value_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [DataW-1:0]     result_value_o;
  logic                        error_o;
  logic [CountOutW-1:0]        entry_count_o;

  list_req_t    pending_requests[$];
  list_result_t expected_results[$];

  data_t        model_entries[Capacity];
  int           model_count = 0;
  int unsigned  error_count = 0;
  logic         req_taken = 1'b0;
  int unsigned  idle_count = 0;
  int unsigned  stall_left = 0;
  int unsigned  calm_left = 0;

  bounded_indexed_list #(
    .Capacity(Capacity)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .position_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .result_value_o,
    .error_o,
    .entry_count_o
  );

  always #1 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic predict_list_op(input logic [KindW-1:0] kind, input logic signed [PosW-1:0] pos,
                                 input data_t val);
    list_result_t r;
    int p;
    int idx;
    int i;
    int lo;
    int hi;
    data_t t;
    r.val = '0;
    r.err = 1'b0;
    p = pos;
    case (kind)
      KindInsert: begin
        if (model_count >= Capacity) begin
          r.err = 1'b1;
        end else begin
          idx = (p <= 0) ? 0 : ((p >= model_count) ? model_count : p);
          for (i = model_count; i > idx; i--) model_entries[i] = model_entries[i-1];
          model_entries[idx] = val;
          model_count++;
        end
      end
      KindReverse: begin
        lo = 0;
        hi = model_count - 1;
        while (lo < hi) begin
          t = model_entries[lo];
          model_entries[lo] = model_entries[hi];
          model_entries[hi] = t;
          lo++;
          hi--;
        end
      end
      default: begin
        if (model_count == 0) begin
          r.err = 1'b1;
        end else begin
          idx = (p <= 0) ? 0 : ((p >= model_count) ? model_count - 1 : p);
          r.val = model_entries[idx];
          if (kind == KindRemove) begin
            for (i = idx; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
            model_count--;
          end
        end
      end
    endcase
    r.cnt = model_count[CountOutW-1:0];
    expected_results.push_back(r);
  endtask

  task automatic add_request(input logic [KindW-1:0] kind, input int pos, input data_t val,
                             input int unsigned gap, input bit drain);
    list_req_t q;
    q.kind = kind;
    q.pos = pos[PosW-1:0];
    q.val = val;
    q.gap = gap;
    q.drain = drain;
    pending_requests.push_back(q);
  endtask

  function automatic int unsigned rand_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int rand_pos();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 19) - 2;
    return $signed($urandom() & 32'h0000_ffff) - (($urandom() & 1) ? 32768 : 0);
  endfunction

  function automatic data_t rand_data();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  always @(negedge clk_i) begin : drive_requests
    list_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !req_taken) begin
      end else if (pending_requests.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_count < pending_requests[0].gap ||
                   (pending_requests[0].drain && expected_results.size() != 0)) begin
        in_valid_i <= 1'b0;
        idle_count <= idle_count + 1;
      end else begin
        nxt = pending_requests.pop_front();
        kind_i <= nxt.kind;
        position_i <= nxt.pos;
        value_i <= nxt.val;
        in_valid_i <= 1'b1;
        idle_count <= 0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_ready
    int unsigned roll;
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_ready_i <= 1'b1;
      calm_left <= calm_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        calm_left <= 120;
        out_ready_i <= 1'b1;
      end else if (roll < 27) begin
        stall_left <= $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else if (roll < 30) begin
        stall_left <= $urandom_range(5, 40);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch_ports
    list_result_t want;
    if (rst_ni) begin
      req_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (result_value_o !== want.val)
            report_error($sformatf("result_value got %h want %h", result_value_o, want.val));
          if (error_o !== want.err)
            report_error($sformatf("error got %b want %b", error_o, want.err));
          if (entry_count_o !== want.cnt)
            report_error($sformatf("entry_count got %0d want %0d", entry_count_o, want.cnt));
        end
      end
      if (in_valid_i && in_ready_o) predict_list_op(kind_i, position_i, value_i);
    end
  end

  initial begin : stimulus
    int dir_pos[16];
    int ins_pct;
    bit calm;
    int unsigned roll;
    logic [KindW-1:0] k;
    dir_pos = '{-32768, 32767, 0, 1, 2, -1, 5, 32767, 3, 7, 0, 10, -5, 4, 20, 8};

    // Empty list first, then fill it to capacity and try one insert too many.
    add_request(KindRead, 0, '0, 0, 1'b0);
    add_request(KindRemove, 32767, '0, 0, 1'b0);
    add_request(KindReverse, 0, '0, 0, 1'b0);
    for (int i = 0; i < 16; i++)
      add_request(KindInsert, dir_pos[i],
                  (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7fff_ffff : data_t'($urandom()),
                  0, 1'b0);
    add_request(KindInsert, 3, 32'sh1234_5678, 0, 1'b0);
    add_request(KindReverse, -32768, '0, 0, 1'b0);
    add_request(KindRead, -32768, '0, 0, 1'b0);
    add_request(KindRead, 32767, '0, 0, 1'b0);
    add_request(KindRead, 6, '0, 0, 1'b0);
    add_request(KindRemove, 6, '0, 0, 1'b0);
    add_request(KindRemove, -1, '0, 0, 1'b0);
    add_request(KindRemove, 32767, '0, 0, 1'b0);

    for (int blk = 0; blk < 9; blk++) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 80;
        1: ins_pct = 15;
        default: ins_pct = 40;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 7);
        if ($urandom_range(0, 99) < ins_pct) k = KindInsert;
        else if (roll < 4) k = KindRemove;
        else if (roll < 7) k = KindRead;
        else k = KindReverse;
        add_request(k, rand_pos(), rand_data(), calm ? 0 : rand_gap(),
                    (blk == 0 && n == 0) || ($urandom_range(0, 59) == 0));
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[bounded_indexed_list.f]
rtl/core/bli_pkg.sv
rtl/core/bli_cell.sv
rtl/core/bli_sel.sv
rtl/core/bounded_indexed_list.sv
tb/sv/tb_top.sv
